@@ hw/rtl/gpit_pkg.sv @@
// Shared types and constants for the GF(2) irreducibility test core.
package gpit_pkg;

    localparam int POLY_BITS_DEF = 64;
    localparam int IN_BITS = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQ_INIT,
        ST_SQ_STEP,
        ST_GCD_INIT,
        ST_GCD_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;

endpackage

@@ hw/rtl/gpit_engine.sv @@
// Sequencer and shared shift/xor datapath for the Ben-Or test.
module gpit_engine #(
    parameter int POLY_BITS = gpit_pkg::POLY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gpit_pkg::IN_BITS-1:0] poly,
    output logic                        done,
    output logic                        result
);
    import gpit_pkg::*;

    localparam int W  = (POLY_BITS < IN_BITS) ? POLY_BITS : IN_BITS;
    localparam int DW = $clog2(W);

    state_t        state_reg, state_next;
    logic [W-1:0]  f_reg, f_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW-1:0] k_reg, k_next;
    logic [DW-1:0] ka_reg, ka_next;
    logic [DW-1:0] i_reg, i_next;
    logic          res_reg, res_next;

    logic [W-1:0]  acc_sh;
    logic [W-1:0]  acc_md;
    logic          b_top;

    always_comb
    begin
        acc_sh = acc_reg << 1;
        acc_md = acc_sh[d_reg] ? (acc_sh ^ f_reg) : acc_sh;
        if (r_reg[k_reg])
            acc_md = acc_md ^ r_reg;
        b_top = b_reg[W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg   <= f_next;
        r_reg   <= r_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        k_reg   <= k_next;
        ka_reg  <= ka_next;
        i_reg   <= i_next;
    end

    // Gcd: a left-aligned with degree ka; b stored as b * x^(W-1-k) with degree <= k.
    always_comb
    begin
        state_next = state_reg;
        f_next = f_reg; r_next = r_reg; acc_next = acc_reg;
        a_next = a_reg; b_next = b_reg; d_next = d_reg;
        k_next = k_reg; ka_next = ka_reg; i_next = i_reg; res_next = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    f_next = poly[W-1:0];
                    d_next = DW'(W - 1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (f_reg == '0 || d_reg == '0)
                begin
                    res_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (f_reg[d_reg])
                begin
                    if (d_reg == DW'(1))
                    begin
                        res_next = f_reg[0];
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        r_next = W'(2);
                        i_next = DW'(1);
                        state_next = ST_SQ_INIT;
                    end
                end
                else
                    d_next = d_reg - DW'(1);
            end
            ST_SQ_INIT:
            begin
                acc_next = '0;
                k_next = d_reg - DW'(1);
                state_next = ST_SQ_STEP;
            end
            ST_SQ_STEP:
            begin
                acc_next = acc_md;
                if (k_reg == '0)
                    state_next = ST_GCD_INIT;
                else
                    k_next = k_reg - DW'(1);
            end
            ST_GCD_INIT:
            begin
                r_next = acc_reg;
                a_next = f_reg << (DW'(W - 1) - d_reg);
                ka_next = d_reg;
                b_next = acc_reg ^ W'(2);
                k_next = DW'(W - 1);
                state_next = ST_GCD_STEP;
            end
            ST_GCD_STEP:
            begin
                if (b_reg == '0)
                begin
                    if (ka_reg == '0)
                    begin
                        if (i_reg == (d_reg >> 1))
                        begin
                            res_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            i_next = i_reg + DW'(1);
                            state_next = ST_SQ_INIT;
                        end
                    end
                    else
                    begin
                        res_next = 1'b0;
                        state_next = ST_DONE;
                    end
                end
                else if (!b_top)
                begin
                    b_next = b_reg << 1;
                    k_next = k_reg - DW'(1);
                end
                else if (k_reg > ka_reg)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    ka_next = k_reg;
                    k_next  = ka_reg;
                end
                else
                begin
                    a_next  = b_reg;
                    ka_next = k_reg;
                    b_next  = a_reg ^ b_reg;
                    k_next  = ka_reg;
                end
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign done   = (state_reg == ST_DONE);
    assign result = res_reg;

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_SCAN)
        else $error("start lost");
    a_gcd_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD_STEP) |-> a_reg[W-1])
        else $error("gcd operand not aligned");
`endif
endmodule

@@ hw/rtl/gf2_poly_irreducibility_test_core.sv @@
// Top level of the GF(2) polynomial irreducibility test core.
//  channel | signals                          | dir
//  in      | in_valid in_ready poly_value     | in
//  out     | out_valid out_ready is_irreducible | out
// One item passes a start state, a scan for the degree, then up to deg/2 rounds
// of modular squaring, each followed by a gcd, then a done state and the
// transfer into the result register.
// in_ready is low from acceptance until the result is transferred.
// Reset clears control; out_valid holds through stalls.
module gf2_poly_irreducibility_test_core #(
    parameter int POLY_BITS = gpit_pkg::POLY_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [gpit_pkg::IN_BITS-1:0] poly_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         is_irreducible
);
    import gpit_pkg::*;

    unit_ctl_t ctl;
    logic      done, res;
    logic      busy_reg, busy_next;
    logic      ov_reg, ov_next;
    logic      res_reg, res_next;

    assign ctl.start = in_valid && in_ready;
    assign ctl.busy  = busy_reg;

    gpit_engine #(.POLY_BITS(POLY_BITS)) u_eng (
        .clk(clk), .rst_n(rst_n), .start(ctl.start), .poly(poly_value),
        .done(done), .result(res)
    );

    always_comb
    begin
        busy_next = busy_reg;
        ov_next   = ov_reg;
        res_next  = res_reg;
        if (ctl.start)
            busy_next = 1'b1;
        if (done)
        begin
            ov_next  = 1'b1;
            res_next = res;
        end
        if (ov_reg && out_ready)
        begin
            ov_next   = 1'b0;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
            res_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
            res_reg  <= res_next;
        end
    end

    assign in_ready       = !ctl.busy;
    assign out_valid      = ov_reg;
    assign is_irreducible = res_reg;

`ifndef SYNTHESIS
    a_ov_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy_reg) else $error("result without item");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg && !out_valid) else $error("stray done");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(is_irreducible))
        else $error("result dropped");
`endif
endmodule

@@ bench/gpit_checker.sv @@
`timescale 1ns / 1ps
// Checker for the GF(2) irreducibility test core: Ben-Or predictor and result compare.
module gpit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] poly_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        is_irreducible,
    output int          outstanding,
    output int          mismatches
);

    bit verdict_q[$];

    function automatic int poly_deg(logic [63:0] a);
        for (int k = 63; k >= 0; k--)
            if (a[k])
                return k;
        return -1;
    endfunction

    function automatic logic [63:0] poly_rem(logic [63:0] a, logic [63:0] m);
        int dm;
        int da;
        dm = poly_deg(m);
        da = poly_deg(a);
        while (da >= dm)
        begin
            a  = a ^ (m << (da - dm));
            da = poly_deg(a);
        end
        return a;
    endfunction

    function automatic logic [63:0] gf2_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = poly_rem(a, b);
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [63:0] poly_sqr_mod(logic [63:0] a, logic [63:0] m, int dm);
        logic [63:0] acc;
        acc = '0;
        for (int k = poly_deg(a); k >= 0; k--)
        begin
            acc = acc << 1;
            if (acc[dm])
                acc = acc ^ m;
            if (a[k])
                acc = acc ^ a;
        end
        return acc;
    endfunction

    function automatic bit ben_or_irreducible(logic [63:0] f);
        logic [63:0] r;
        int d;
        if (f == 0 || f == 1 || f == 2)
            return 1'b0;
        d = poly_deg(f);
        if (d == 1)
            return 1'b1;
        r = 64'd2;
        for (int i = 1; i <= d / 2; i++)
        begin
            r = poly_sqr_mod(r, f, d);
            if (gf2_gcd(f, r ^ 64'd2) != 64'd1)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        bit exp_v;
        if (!rst_n)
        begin
            mismatches  = 0;
            outstanding = 0;
            verdict_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                verdict_q.push_back(ben_or_irreducible(poly_value));
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    exp_v = verdict_q.pop_front();
                    if (is_irreducible !== exp_v)
                        report_mismatch($sformatf("is_irreducible %b, expected %b",
                                                  is_irreducible, exp_v));
                end
            end
            outstanding = verdict_q.size();
        end
    end

endmodule

@@ bench/gf2_poly_irreducibility_test_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the GF(2) irreducibility test core: clock, reset, stimulus, verdict.
module gf2_poly_irreducibility_test_core_tb;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] poly_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_irreducible;
    int          outstanding;
    int          mismatches;
    int          hold_reqs = 0;
    int          burst_left = 0;

    logic [63:0] irred_list[8] = '{64'h7, 64'hB, 64'h25, 64'h83, 64'h11B, 64'h8003,
                                   64'h8000_0009, 64'h8000_0000_0000_0003};

    always #6 clk = ~clk;

    gf2_poly_irreducibility_test_core dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .poly_value(poly_value), .out_valid(out_valid), .out_ready(out_ready),
        .is_irreducible(is_irreducible)
    );

    gpit_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .poly_value(poly_value), .out_valid(out_valid), .out_ready(out_ready),
        .is_irreducible(is_irreducible), .outstanding(outstanding),
        .mismatches(mismatches)
    );

    // hold off the receiver on request, otherwise stall on a shifting pattern
    initial
    begin
        int mode;
        int left;
        int served;
        mode = 0;
        left = 0;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != served)
            begin
                served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 400);
            end
            left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 20) == 0);
            endcase
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT)
            begin
                $display("** gf2_poly_irreducibility_test_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_poly(logic [63:0] p);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = $urandom_range(1, 6);
        end
        burst_left--;
        in_valid   <= 1'b1;
        poly_value <= p;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [63:0] random_poly();
        logic [63:0] p;
        int d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                d = $urandom_range(2, 20);
                p = {$urandom, $urandom};
                p = (p & ((64'd1 << d) - 1)) | (64'd1 << d);
            end
            4, 5:
                p = irred_list[3'($urandom_range(0, 5))];
            6:
                p = irred_list[3'($urandom_range(0, 7))];
            7:
                p = {$urandom, $urandom} & {$urandom, $urandom};
            default:
                p = {$urandom, $urandom};
        endcase
        return p;
    endfunction

    initial
    begin
        logic [63:0] directed[$];
        directed = '{64'h0, 64'h1, 64'h2, 64'h3, 64'h6, 64'h12, 64'h7, 64'h13, 64'h5,
                     64'hB, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                     64'h8000_0000_0000_0003, 64'h8000_0000_0000_0001,
                     64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h11B, 64'h8003};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_poly(directed[i]);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        hold_reqs++;
        for (int i = 0; i < 100; i++)
        begin
            if (i == 30)
                hold_reqs++;
            if (i == 60)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (outstanding == 0);
            end
            send_poly(random_poly());
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("** gf2_poly_irreducibility_test_core: PASSED **");
        else
            $display("** gf2_poly_irreducibility_test_core: FAILED **");
        $finish;
    end

endmodule

@@ gf2_poly_irreducibility_test_core.f @@
hw/rtl/gpit_pkg.sv
hw/rtl/gpit_engine.sv
hw/rtl/gf2_poly_irreducibility_test_core.sv
bench/gpit_checker.sv
bench/gf2_poly_irreducibility_test_core_tb.sv
